/* hdl/jacobi_linear_solver_assert.svh */
// ----------------------------------------------------------------------------
// Jacobi solver assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JACOBI_LINEAR_SOLVER_ASSERT_SVH
`define JACOBI_LINEAR_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define JLS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define JLS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define JLS_ASSERT_IMP(label, ante, cons, msg)
`define JLS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* hdl/jls_pkg.sv */
// ----------------------------------------------------------------------------
// Jacobi solver package
// Shared types, codes and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package jls_pkg;

	localparam logic [1:0] KIND_LOAD_MAT = 2'd0;
	localparam logic [1:0] KIND_LOAD_RHS = 2'd1;
	localparam logic [1:0] KIND_SOLVE    = 2'd2;

	localparam logic [1:0] STATUS_CONVERGED = 2'd0;
	localparam logic [1:0] STATUS_ZERO_DIAG = 2'd1;
	localparam logic [1:0] STATUS_LIMIT     = 2'd2;

	localparam logic [1:0] REG_SYSTEM_SIZE = 2'd0;
	localparam logic [1:0] REG_TOLERANCE   = 2'd1;
	localparam logic [1:0] REG_ITER_LIMIT  = 2'd2;

	localparam logic [4:0]  RST_SYSTEM_SIZE = 5'd4;
	localparam logic [30:0] RST_TOLERANCE   = 31'd66;
	localparam logic [15:0] RST_ITER_LIMIT  = 16'd1000;

	typedef struct packed {
		logic [4:0]  size;
		logic [30:0] tol;
		logic [15:0] limit;
	} cfg_t;

	typedef struct packed {
		logic [15:0] iters;
		logic [30:0] residual;
		logic [31:0] value;
		logic [3:0]  idx;
		logic [1:0]  status;
		logic        last;
	} res_t;

	// truncated quotient magnitude plus sign, saturated to 32 bits
	function automatic logic [31:0] fix_sat(input logic [63:0] q, input logic neg);
		if (!neg)
			return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		return (q > 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
	endfunction

	function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

/* hdl/jls_div.sv */
// ----------------------------------------------------------------------------
// Jacobi solver divider
// Unsigned 64 by 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jls_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[31:0], quo_q[63]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

/* hdl/jls_sqrt.sv */
// ----------------------------------------------------------------------------
// Jacobi solver square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jls_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];
endmodule

/* hdl/jls_core.sv */
// ----------------------------------------------------------------------------
// Jacobi solver core
// Stores, sequencer and shared multiplier; drives the divider and root units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jls_core #(
	parameter int MAX_SIZE      = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  jls_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_kind,
	input  logic [3:0]         in_row,
	input  logic [3:0]         in_col,
	input  logic signed [31:0] in_value,
	output logic               out_valid,
	input  logic               out_ready,
	output jls_pkg::res_t      out_res
);
	import jls_pkg::*;

	localparam int IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int AW  = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int XAW = $clog2(2 * MAX_SIZE);
	localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

	localparam logic [4:0] S_IDLE = 5'd0, S_DG_RD = 5'd1, S_DG_CHK = 5'd2, S_ROW_RD = 5'd3,
		S_ROW_LAT = 5'd4, S_BETA_WT = 5'd5, S_EL_RD = 5'd6, S_EL_LAT = 5'd7, S_EL_WT = 5'd8,
		S_EL_MUL = 5'd9, S_EL_SQ = 5'd10, S_NRM = 5'd11, S_NRM_WT = 5'd12, S_TH_MUL = 5'd13,
		S_TH_DIV = 5'd14, S_TH_WT = 5'd15, S_IT_START = 5'd16, S_RW_RD = 5'd17,
		S_RW_INIT = 5'd18, S_MC_RD = 5'd19, S_MC_MUL = 5'd20, S_MC_ACC = 5'd21, S_WR = 5'd22,
		S_DL = 5'd23, S_DL_MUL = 5'd24, S_DL_SQ = 5'd25, S_ST_SQ = 5'd26, S_ST_WT = 5'd27,
		S_EM_RD = 5'd28, S_EM_OUT = 5'd29;

	function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(int'(r) * MAX_SIZE + int'(c));
	endfunction

	function automatic logic [XAW-1:0] x_addr(input logic b, input logic [IW-1:0] i);
		return XAW'(int'(b) * MAX_SIZE + int'(i));
	endfunction

	// stores
	logic [31:0] mat_mem  [MAX_SIZE*MAX_SIZE];
	logic [31:0] coef_mem [MAX_SIZE*MAX_SIZE];
	logic [31:0] rhs_mem  [MAX_SIZE];
	logic [31:0] beta_mem [MAX_SIZE];
	logic [31:0] x_mem    [2*MAX_SIZE];
	logic [31:0] mat_rd_q, coef_rd_q, rhs_rd_q, beta_rd_q, x_rd_q;

	logic [4:0]        state_q;
	logic [IW-1:0]     i_q, j_q, n_m1_q;
	logic              cur_q, zd_q, unb_q, neg_q, big_q, ov_q;
	logic [15:0]       iter_q;
	logic [31:0]       d_q, alpha_q, xnew_q, mg_q, norm_q, step_q;
	logic [63:0]       sumsq_q, acc2_q, thresh_q;
	logic signed [63:0] acc_q;
	logic [1:0]        status_q;
	logic signed [65:0] prod_s1;
	res_t              res_q;

	logic              accept, row_ok, col_ok;
	logic [AW-1:0]     mat_ra;
	logic [XAW-1:0]    x_ra, x_wa;
	logic              coef_we, beta_we, x_we, mat_we, rhs_we;
	logic [31:0]       coef_wd, x_wd;
	logic              div_start, div_done, sq_start, sq_done;
	logic [63:0]       div_dvd, div_quo, sq_rad;
	logic [31:0]       div_dvs, sq_root;
	logic signed [32:0] mul_a, mul_b;
	logic [31:0]       fix_a, alpha_n, xsat, alpha_mag;
	logic signed [32:0] delta;
	logic [32:0]       dmag;
	logic              emit, last_j, last_i;
	logic [15:0]       lim_eff;
	logic [IW-1:0]     n_m1_in;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign row_ok  = int'(in_row) < MAX_SIZE;
	assign col_ok  = int'(in_col) < MAX_SIZE;
	assign mat_we  = accept && (in_kind == KIND_LOAD_MAT) && row_ok && col_ok;
	assign rhs_we  = accept && (in_kind == KIND_LOAD_RHS) && row_ok;
	assign last_j  = (j_q == n_m1_q);
	assign last_i  = (i_q == n_m1_q);
	assign lim_eff = (cfg.limit == 16'd0) ? 16'd1 : cfg.limit;
	assign emit    = (state_q == S_EM_OUT) && (!ov_q || out_ready);

	always_comb begin
		if (cfg.size == 5'd0)
			n_m1_in = '0;
		else if (int'(cfg.size) > MAX_SIZE)
			n_m1_in = IW'(MAX_SIZE - 1);
		else
			n_m1_in = IW'(cfg.size - 5'd1);
	end

	// read addresses follow the counters; data is registered
	assign mat_ra = (state_q == S_DG_RD || state_q == S_ROW_RD) ? mat_addr(i_q, i_q)
		: mat_addr(i_q, j_q);
	assign x_ra   = (state_q == S_MC_RD) ? x_addr(cur_q, j_q) : x_addr(cur_q, i_q);

	always_ff @(posedge clk) begin
		if (mat_we)
			mat_mem[mat_addr(IW'(in_row), IW'(in_col))] <= in_value;
		mat_rd_q <= mat_mem[mat_ra];
	end

	always_ff @(posedge clk) begin
		if (rhs_we)
			rhs_mem[IW'(in_row)] <= in_value;
		rhs_rd_q <= rhs_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[mat_addr(i_q, j_q)] <= coef_wd;
		coef_rd_q <= coef_mem[mat_addr(i_q, j_q)];
	end

	always_ff @(posedge clk) begin
		if (beta_we)
			beta_mem[i_q] <= x_wd;
		beta_rd_q <= beta_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (x_we)
			x_mem[x_wa] <= x_wd;
		x_rd_q <= x_mem[x_ra];
	end

	// arithmetic around the units
	assign fix_a     = fix_sat(div_quo, neg_q);
	assign alpha_n   = (fix_a == 32'h8000_0000) ? 32'h7FFF_FFFF : (~fix_a + 32'd1);
	// alpha never reaches the most negative code, so its magnitude fits 31 bits
	assign alpha_mag = mag32(alpha_q);
	assign delta     = {xnew_q[31], xnew_q} - {x_rd_q[31], x_rd_q};
	assign dmag      = delta[32] ? 33'(-delta) : 33'(delta);

	always_comb begin
		if (acc_q > 64'sh7FFF_FFFF)
			xsat = 32'h7FFF_FFFF;
		else if (acc_q < -64'sh8000_0000)
			xsat = 32'h8000_0000;
		else
			xsat = acc_q[31:0];
	end

	always_comb begin
		coef_we   = 1'b0;
		coef_wd   = '0;
		beta_we   = 1'b0;
		x_we      = 1'b0;
		x_wa      = x_addr(1'b0, i_q);
		x_wd      = fix_a;
		div_start = 1'b0;
		div_dvd   = 64'(mag32(mat_rd_q)) << FRACTION_BITS;
		div_dvs   = mag32(d_q);
		sq_start  = 1'b0;
		sq_rad    = sumsq_q;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_ROW_LAT: begin
				div_start = 1'b1;
				div_dvd   = 64'(mag32(rhs_rd_q)) << FRACTION_BITS;
				div_dvs   = mag32(mat_rd_q);
			end
			S_BETA_WT: begin
				beta_we = div_done;
				x_we    = div_done;
			end
			S_EL_RD: begin
				coef_we = (i_q == j_q);
			end
			S_EL_LAT: div_start = 1'b1;
			S_EL_WT: begin
				coef_we = div_done;
				coef_wd = alpha_n;
			end
			S_EL_MUL: begin
				mul_a = {1'b0, alpha_mag};
				mul_b = {1'b0, alpha_mag};
			end
			S_NRM: sq_start = 1'b1;
			S_TH_MUL: begin
				mul_a = 33'(ONE - {32'd0, norm_q});
				mul_b = {2'b00, cfg.tol};
			end
			S_TH_DIV: begin
				div_start = 1'b1;
				div_dvd   = prod_s1[63:0];
				div_dvs   = norm_q;
			end
			S_MC_MUL: begin
				mul_a = {coef_rd_q[31], coef_rd_q};
				mul_b = {x_rd_q[31], x_rd_q};
			end
			S_WR: begin
				x_we = 1'b1;
				x_wa = x_addr(~cur_q, i_q);
				x_wd = xsat;
			end
			S_DL_MUL: begin
				mul_a = {1'b0, mg_q};
				mul_b = {1'b0, mg_q};
			end
			S_ST_SQ: begin
				sq_start = 1'b1;
				sq_rad   = acc2_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk)
		prod_s1 <= mul_a * mul_b;

	jls_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_quo)
	);

	jls_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_rad),
		.done(sq_done), .root(sq_root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			n_m1_q   <= '0;
			cur_q    <= 1'b0;
			zd_q     <= 1'b0;
			unb_q    <= 1'b0;
			neg_q    <= 1'b0;
			big_q    <= 1'b0;
			iter_q   <= '0;
			d_q      <= '0;
			alpha_q  <= '0;
			xnew_q   <= '0;
			mg_q     <= '0;
			norm_q   <= '0;
			step_q   <= '0;
			sumsq_q  <= '0;
			acc2_q   <= '0;
			thresh_q <= '0;
			acc_q    <= '0;
			status_q <= STATUS_CONVERGED;
		end else begin
			unique case (state_q) inside
				S_IDLE: begin
					if (accept && in_kind == KIND_SOLVE) begin
						n_m1_q   <= n_m1_in;
						i_q      <= '0;
						j_q      <= '0;
						cur_q    <= 1'b0;
						zd_q     <= 1'b0;
						unb_q    <= 1'b0;
						iter_q   <= '0;
						step_q   <= '0;
						sumsq_q  <= '0;
						thresh_q <= '0;
						status_q <= STATUS_CONVERGED;
						state_q  <= S_DG_RD;
					end
				end
				S_DG_RD: state_q <= S_DG_CHK;
				S_DG_CHK: begin
					if (mat_rd_q == 32'd0) begin
						zd_q     <= 1'b1;
						status_q <= STATUS_ZERO_DIAG;
						i_q      <= '0;
						state_q  <= S_EM_RD;
					end else if (last_i) begin
						i_q     <= '0;
						state_q <= S_ROW_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_DG_RD;
					end
				end
				S_ROW_RD: state_q <= S_ROW_LAT;
				S_ROW_LAT: begin
					d_q     <= mat_rd_q;
					neg_q   <= rhs_rd_q[31] ^ mat_rd_q[31];
					state_q <= S_BETA_WT;
				end
				S_BETA_WT: begin
					if (div_done) begin
						j_q     <= '0;
						state_q <= S_EL_RD;
					end
				end
				S_EL_RD, S_EL_SQ: begin
					if (state_q == S_EL_SQ)
						sumsq_q <= add_sat64(sumsq_q, prod_s1[63:0]);
					if (state_q == S_EL_RD && i_q != j_q) begin
						state_q <= S_EL_LAT;
					end else if (!last_j) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_EL_RD;
					end else if (!last_i) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ROW_RD;
					end else begin
						state_q <= S_NRM;
					end
				end
				S_EL_LAT: begin
					neg_q   <= mat_rd_q[31] ^ d_q[31];
					state_q <= S_EL_WT;
				end
				S_EL_WT: begin
					if (div_done) begin
						alpha_q <= alpha_n;
						state_q <= S_EL_MUL;
					end
				end
				S_EL_MUL: state_q <= S_EL_SQ;
				S_NRM: state_q <= S_NRM_WT;
				S_NRM_WT: begin
					if (sq_done) begin
						norm_q <= sq_root;
						if (sq_root == 32'd0) begin
							unb_q   <= 1'b1;
							state_q <= S_IT_START;
						end else if ({32'd0, sq_root} >= ONE) begin
							state_q <= S_IT_START;
						end else begin
							state_q <= S_TH_MUL;
						end
					end
				end
				S_TH_MUL: state_q <= S_TH_DIV;
				S_TH_DIV: state_q <= S_TH_WT;
				S_TH_WT: begin
					if (div_done) begin
						thresh_q <= div_quo;
						state_q  <= S_IT_START;
					end
				end
				S_IT_START: begin
					iter_q  <= iter_q + 16'd1;
					i_q     <= '0;
					acc2_q  <= '0;
					state_q <= S_RW_RD;
				end
				S_RW_RD: state_q <= S_RW_INIT;
				S_RW_INIT: begin
					acc_q   <= 64'(signed'(beta_rd_q));
					j_q     <= '0;
					state_q <= S_MC_RD;
				end
				S_MC_RD: state_q <= S_MC_MUL;
				S_MC_MUL: state_q <= S_MC_ACC;
				S_MC_ACC: begin
					// arithmetic shift floors the product to the fraction grid
					acc_q <= acc_q + 64'(prod_s1 >>> FRACTION_BITS);
					if (last_j) begin
						state_q <= S_WR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_MC_RD;
					end
				end
				S_WR: begin
					xnew_q  <= xsat;
					state_q <= S_DL;
				end
				S_DL: begin
					big_q   <= dmag[32];
					mg_q    <= dmag[31:0];
					state_q <= S_DL_MUL;
				end
				S_DL_MUL: state_q <= S_DL_SQ;
				S_DL_SQ: begin
					acc2_q <= add_sat64(acc2_q, big_q ? 64'hFFFF_FFFF_FFFF_FFFF : prod_s1[63:0]);
					if (last_i) begin
						state_q <= S_ST_SQ;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RW_RD;
					end
				end
				S_ST_SQ: state_q <= S_ST_WT;
				S_ST_WT: begin
					if (sq_done) begin
						step_q <= sq_root;
						cur_q  <= ~cur_q;
						i_q    <= '0;
						if (unb_q || {32'd0, sq_root} < thresh_q) begin
							status_q <= STATUS_CONVERGED;
							state_q  <= S_EM_RD;
						end else if (iter_q >= lim_eff) begin
							status_q <= STATUS_LIMIT;
							state_q  <= S_EM_RD;
						end else begin
							state_q <= S_IT_START;
						end
					end
				end
				S_EM_RD: state_q <= S_EM_OUT;
				S_EM_OUT: begin
					if (emit) begin
						if (last_i) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (emit)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.idx      <= 4'(i_q);
			res_q.value    <= zd_q ? 32'd0 : x_rd_q;
			res_q.residual <= step_q[31] ? 31'h7FFF_FFFF : step_q[30:0];
			res_q.iters    <= iter_q;
			res_q.status   <= status_q;
			res_q.last     <= last_i;
		end
	end

	assign out_valid = ov_q;
	assign out_res   = res_q;
endmodule

/* hdl/jacobi_linear_solver.sv */
// ----------------------------------------------------------------------------
// Jacobi linear solver
// Fixed-point Jacobi iteration with matrix load, solve and result streams.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                         Handshake
// s_*      in   tuser kind; tdata row, column, element_value    tvalid/tready
// m_*      out  tuser status; tdata index, value, residual,     tvalid/tready
//               iterations; tlast on last result of a solve
// APB      in   system_size, tolerance, iteration_limit @0,4,8  pready tied high
//
// Loads are written as they are accepted. A solve holds s_tready low through
// a diagonal check, then per row a beta division plus one division per
// off-diagonal element (64-step divider), then the norm square root and an
// optional threshold division. Each iteration is paced by the single shared
// multiplier and the memory read latency; each result is read, then emitted.
// Reset is asynchronous and needs no clearing pass. A stalled m_tready holds
// the result register; the next result waits until that register drains.
`timescale 1ns / 1ps
`include "jacobi_linear_solver_assert.svh"
module jacobi_linear_solver #(
	parameter int MAX_SIZE      = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // row[3:0], column[7:4], element_value[39:8]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // solution_index[3:0], solution_value[35:4],
	                               // residual[66:36], iterations_done[82:67], zero
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import jls_pkg::*;

	cfg_t cfg_q;
	res_t res;
	logic wr_en;

	// register file: written on the access phase of an APB request
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size  <= RST_SYSTEM_SIZE;
			cfg_q.tol   <= RST_TOLERANCE;
			cfg_q.limit <= RST_ITER_LIMIT;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SYSTEM_SIZE: cfg_q.size  <= pwdata[4:0];
				REG_TOLERANCE:   cfg_q.tol   <= pwdata[30:0];
				REG_ITER_LIMIT:  cfg_q.limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SYSTEM_SIZE: prdata = {27'd0, cfg_q.size};
			REG_TOLERANCE:   prdata = {1'b0, cfg_q.tol};
			REG_ITER_LIMIT:  prdata = {16'd0, cfg_q.limit};
			default:         prdata = 32'd0;
		endcase
	end

	jls_core #(
		.MAX_SIZE(MAX_SIZE),
		.FRACTION_BITS(FRACTION_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_kind(s_tuser),
		.in_row(s_tdata[3:0]),
		.in_col(s_tdata[7:4]),
		.in_value(s_tdata[39:8]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(res)
	);

	assign m_tdata = {5'd0, res.iters, res.residual, res.value, res.idx};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

	// a solve request closes the input until its results are out
	`JLS_ASSERT_NXT(a_solve_blocks, s_tvalid && s_tready && s_tuser == KIND_SOLVE, !s_tready, "input open after solve request")
	// a zero diagonal gives zero values, zero residual and no iterations
	`JLS_ASSERT_IMP(a_zero_diag, m_tvalid && m_tuser == STATUS_ZERO_DIAG, m_tdata[82:4] == 79'd0, "zero diagonal result not cleared")
	// any computed result has run at least one iteration
	`JLS_ASSERT_IMP(a_iter_nonzero, m_tvalid && m_tuser != STATUS_ZERO_DIAG, m_tdata[82:67] != 16'd0, "computed result without iterations")
endmodule
